// ===== src/lmbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lmbp_pkg: shared definitions for the LED matrix bus peripheral
// Frame geometry, register offsets, request kinds and the draw patterns.
// ----------------------------------------------------------------------------
package lmbp_pkg;

    localparam int MATRIX_WIDTH  = 32;
    localparam int MATRIX_HEIGHT = 16;
    localparam int COL_W         = $clog2(MATRIX_WIDTH);
    localparam int ROW_W         = $clog2(MATRIX_HEIGHT);
    // Shape half-extent; patterns below span offsets -2..+2.
    localparam int SHAPE_R       = 2;
    localparam int PAT_W         = 2 * SHAPE_R + 1;

    localparam logic [31:0] BASE_ADDR_RESET = 32'd16384;

    typedef enum logic {
        REQ_BUS = 1'b0,
        REQ_ROW = 1'b1
    } req_kind_t;

    typedef enum logic [2:0] {
        OFF_CURSOR_X = 3'd0,
        OFF_CURSOR_Y = 3'd1,
        OFF_PIXEL    = 3'd2,
        OFF_DIAMOND  = 3'd3,
        OFF_SQUARE   = 3'd4
    } reg_offset_t;

    // Column patterns, bit k is column offset k - SHAPE_R.
    localparam logic [PAT_W-1:0] PAT_CENTER = 5'b00100;
    localparam logic [PAT_W-1:0] PAT_NEAR   = 5'b01010;
    localparam logic [PAT_W-1:0] PAT_FAR    = 5'b10001;
    localparam logic [PAT_W-1:0] PAT_FULL   = 5'b11111;

    typedef logic [MATRIX_WIDTH-1:0] row_t;

endpackage

// ===== src/led_matrix_bus_peripheral.sv =====
// ----------------------------------------------------------------------------
// led_matrix_bus_peripheral: bus-mapped driver for a monochrome LED frame
// Five registers at base_address+0..4 set the cursor, a pixel, or draw a
// diamond or square outline; a second request kind reads one frame row.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready): one request per accepted beat. s_req_type 0 is
//     a bus cycle (s_bus_req, s_bus_address, s_bus_data), 1 reads the frame
//     row s_display_row.
//   m_* channel (valid/ready): one result per request: ack line, row pixels
//     (zero for bus cycles), cursor column and row after the request.
//   cfg_* channel (valid/ready): writes base_address; always ready. Write it
//     only while no request is in flight.
//   Path: an accepted request passes the input register, then the
//     update/result register. Throughput: one request per cycle while the
//     result register drains; the state update for a request is registered
//     with its result, so back-to-back requests see each other's effects.
//   Reset (aresetn low, synchronous): frame cleared, cursor 0, ack low,
//     base_address 16384, both pipeline stages emptied.
//   Stall: if m_ready is low the result register holds; the input register
//     still takes one more request, then s_ready drops until the result drains.
// ----------------------------------------------------------------------------
module led_matrix_bus_peripheral
    import lmbp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [31:0]             cfg_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic                    s_bus_req,
    input  logic [31:0]             s_bus_address,
    input  logic signed [31:0]      s_bus_data,
    input  logic [3:0]              s_display_row,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_ack,
    output logic [31:0]             m_row_pixels,
    output logic [4:0]              m_cursor_col,
    output logic [3:0]              m_cursor_row
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [31:0] base_addr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg <= BASE_ADDR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            base_addr_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    req_kind_t          in_kind_reg;
    logic               in_req_reg;
    logic [31:0]        in_addr_reg;
    logic signed [31:0] in_data_reg;
    logic [3:0]         in_row_reg;
    logic               advance;   // input stage moves into result stage

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= req_kind_t'(s_req_type);
            in_req_reg  <= s_bus_req;
            in_addr_reg <= s_bus_address;
            in_data_reg <= s_bus_data;
            in_row_reg  <= s_display_row;
        end
    end

    // ------------------------------------------------------------------
    // Peripheral state
    // ------------------------------------------------------------------
    row_t [MATRIX_HEIGHT-1:0] frame_reg;
    row_t [MATRIX_HEIGHT-1:0] frame_next;
    logic [COL_W-1:0]         cursor_x_reg, cursor_x_next;
    logic [ROW_W-1:0]         cursor_y_reg, cursor_y_next;
    logic                     ack_flag_reg, ack_flag_next;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    logic [31:0] offset;
    logic        bus_hit;
    logic        do_action;
    logic        data_pos;     // data >= 1
    logic        data_nonneg;
    reg_offset_t off_code;

    assign offset      = in_addr_reg - base_addr_reg;
    assign bus_hit     = (in_kind_reg == REQ_BUS) && (offset <= 32'(OFF_SQUARE));
    assign do_action   = bus_hit && in_req_reg && !ack_flag_reg;
    assign data_nonneg = !in_data_reg[31];
    assign data_pos    = data_nonneg && (in_data_reg != 32'sd0);
    assign off_code    = reg_offset_t'(offset[2:0]);

    // Column masks around the cursor, clipped at both frame edges by
    // shifting a pattern into a word padded by SHAPE_R on each side.
    localparam int WIDE_W = MATRIX_WIDTH + 2 * SHAPE_R;

    logic [WIDE_W-1:0] wide_center, wide_near, wide_far, wide_full;
    row_t              mask_center, mask_near, mask_far, mask_full;
    row_t              mask_cursor;

    assign wide_center = WIDE_W'(PAT_CENTER) << cursor_x_reg;
    assign wide_near   = WIDE_W'(PAT_NEAR)   << cursor_x_reg;
    assign wide_far    = WIDE_W'(PAT_FAR)    << cursor_x_reg;
    assign wide_full   = WIDE_W'(PAT_FULL)   << cursor_x_reg;
    assign mask_center = wide_center[MATRIX_WIDTH+SHAPE_R-1:SHAPE_R];
    assign mask_near   = wide_near[MATRIX_WIDTH+SHAPE_R-1:SHAPE_R];
    assign mask_far    = wide_far[MATRIX_WIDTH+SHAPE_R-1:SHAPE_R];
    assign mask_full   = wide_full[MATRIX_WIDTH+SHAPE_R-1:SHAPE_R];
    assign mask_cursor = mask_center;

    // Row distance from the cursor, one per frame row.
    logic signed [ROW_W+1:0] row_dy [MATRIX_HEIGHT];

    always_comb begin
        for (int r = 0; r < MATRIX_HEIGHT; r++) begin
            row_dy[r] = $signed({2'b00, ROW_W'(r)}) - $signed({2'b00, cursor_y_reg});
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        ack_flag_next = ack_flag_reg;
        frame_next    = frame_reg;

        if (do_action) begin
            ack_flag_next = 1'b1;
            unique case (off_code)
                OFF_CURSOR_X: begin
                    if (data_nonneg && (in_data_reg < 32'(MATRIX_WIDTH))) begin
                        cursor_x_next = in_data_reg[COL_W-1:0];
                    end
                end
                OFF_CURSOR_Y: begin
                    if (data_nonneg && (in_data_reg < 32'(MATRIX_HEIGHT))) begin
                        cursor_y_next = in_data_reg[ROW_W-1:0];
                    end
                end
                OFF_PIXEL: begin
                    for (int r = 0; r < MATRIX_HEIGHT; r++) begin
                        if (row_dy[r] == '0) begin
                            if (data_pos) begin
                                frame_next[r] = frame_reg[r] | mask_cursor;
                            end else begin
                                frame_next[r] = frame_reg[r] & ~mask_cursor;
                            end
                        end
                    end
                end
                OFF_DIAMOND: begin
                    if (data_pos) begin
                        for (int r = 0; r < MATRIX_HEIGHT; r++) begin
                            if (row_dy[r] == 6'sd2 || row_dy[r] == -6'sd2) begin
                                frame_next[r] = frame_reg[r] | mask_center;
                            end else if (row_dy[r] == 6'sd1 || row_dy[r] == -6'sd1) begin
                                frame_next[r] = frame_reg[r] | mask_near;
                            end else if (row_dy[r] == 6'sd0) begin
                                frame_next[r] = frame_reg[r] | mask_far;
                            end
                        end
                    end
                end
                default: begin
                    // square outline
                    if (data_pos) begin
                        for (int r = 0; r < MATRIX_HEIGHT; r++) begin
                            if (row_dy[r] == 6'sd2 || row_dy[r] == -6'sd2) begin
                                frame_next[r] = frame_reg[r] | mask_full;
                            end else if (row_dy[r] == 6'sd1 || row_dy[r] == -6'sd1
                                         || row_dy[r] == 6'sd0) begin
                                frame_next[r] = frame_reg[r] | mask_far;
                            end
                        end
                    end
                end
            endcase
        end else if (bus_hit && ack_flag_reg) begin
            ack_flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg    <= '0;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            ack_flag_reg <= 1'b0;
        end else if (advance) begin
            frame_reg    <= frame_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            ack_flag_reg <= ack_flag_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    row_t row_read;

    always_comb begin
        row_read = '0;
        if (in_kind_reg == REQ_ROW && 32'(in_row_reg) < 32'(MATRIX_HEIGHT)) begin
            row_read = frame_reg[in_row_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_ack        <= ack_flag_next;
            m_row_pixels <= row_read;
            m_cursor_col <= cursor_x_next;
            m_cursor_row <= cursor_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(cursor_x_reg) && $stable(cursor_y_reg)
                     && $stable(ack_flag_reg) && $stable(frame_reg))
        else $error("peripheral state changed without a request");

    a_row_read_passive: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_kind_reg == REQ_ROW |=> $stable(frame_reg)
                                             && $stable(ack_flag_reg))
        else $error("row read modified frame or ack");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_result_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_ack == ack_flag_reg)
        else $error("result ack differs from ack flag");
`endif

endmodule

// ===== dv/lmbp_frame_checker.sv =====
// ----------------------------------------------------------------------------
// lmbp_frame_checker: predicts and checks LED matrix peripheral results
// Keeps its own frame, cursor, ack line and base address, updated on every
// accepted request and base write, and compares each accepted result with
// the oldest predicted status.
// ----------------------------------------------------------------------------
module lmbp_frame_checker
    import lmbp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [31:0]        cfg_data,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_req_type,
    input  logic               s_bus_req,
    input  logic [31:0]        s_bus_address,
    input  logic signed [31:0] s_bus_data,
    input  logic [3:0]         s_display_row,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_ack,
    input  logic [31:0]        m_row_pixels,
    input  logic [4:0]         m_cursor_col,
    input  logic [3:0]         m_cursor_row,

    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic             ack;
        row_t             pixels;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } bus_status_t;

    row_t             frame [MATRIX_HEIGHT];
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             ack_line;
    logic [31:0]      base;
    bus_status_t      status_q [$];
    int               errs;

    // Off-frame points are dropped.
    function automatic void light(int x, int y, logic on);
        if (x >= 0 && x < MATRIX_WIDTH && y >= 0 && y < MATRIX_HEIGHT)
            frame[y][x] = on;
    endfunction

    // Diamond: |dx|+|dy| == R. Square outline: max(|dx|,|dy|) == R.
    function automatic void draw_outline(logic is_diamond);
        int ax;
        int ay;
        for (int dy = -SHAPE_R; dy <= SHAPE_R; dy++) begin
            for (int dx = -SHAPE_R; dx <= SHAPE_R; dx++) begin
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                if (is_diamond ? (ax + ay == SHAPE_R) : (ax == SHAPE_R || ay == SHAPE_R))
                    light(int'(cur_col) + dx, int'(cur_row) + dy, 1'b1);
            end
        end
    endfunction

    function automatic bus_status_t model_request(logic kind, logic req, logic [31:0] addr,
                                                  logic signed [31:0] data, logic [3:0] rsel);
        bus_status_t st;
        logic [31:0] offset;
        st.pixels = '0;
        if (kind == REQ_ROW) begin
            if (rsel < MATRIX_HEIGHT)
                st.pixels = frame[rsel];
        end else begin
            offset = addr - base;
            if (offset <= OFF_SQUARE) begin
                if (req && !ack_line) begin
                    ack_line = 1'b1;
                    case (reg_offset_t'(offset[2:0]))
                        OFF_CURSOR_X: if (data >= 0 && data < MATRIX_WIDTH)
                            cur_col = data[COL_W-1:0];
                        OFF_CURSOR_Y: if (data >= 0 && data < MATRIX_HEIGHT)
                            cur_row = data[ROW_W-1:0];
                        OFF_PIXEL:    light(int'(cur_col), int'(cur_row), data >= 1);
                        OFF_DIAMOND:  if (data >= 1) draw_outline(1'b1);
                        default:      if (data >= 1) draw_outline(1'b0);
                    endcase
                end else if (ack_line) begin
                    ack_line = 1'b0;
                end
            end
        end
        st.ack = ack_line;
        st.col = cur_col;
        st.row = cur_row;
        return st;
    endfunction

    always @(posedge aclk) begin : track
        bus_status_t want;
        bus_status_t got;
        if (!aresetn) begin
            for (int i = 0; i < MATRIX_HEIGHT; i++)
                frame[i] = '0;
            cur_col  = '0;
            cur_row  = '0;
            ack_line = 1'b0;
            base     = BASE_ADDR_RESET;
            status_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                base = cfg_data;
            if (m_valid && m_ready) begin
                got = '{m_ack, m_row_pixels, m_cursor_col, m_cursor_row};
                if (status_q.size() == 0) begin
                    if (errs < 10)
                        $display("unexpected result: ack=%0b row=%h col=%0d row_idx=%0d",
                                 got.ack, got.pixels, got.col, got.row);
                    errs++;
                end else begin
                    want = status_q.pop_front();
                    if (got.ack !== want.ack || got.pixels !== want.pixels ||
                        got.col !== want.col || got.row !== want.row) begin
                        if (errs < 10)
                            $display("mismatch: exp ack=%0b row=%h col=%0d row_idx=%0d / got ack=%0b row=%h col=%0d row_idx=%0d",
                                     want.ack, want.pixels, want.col, want.row,
                                     got.ack, got.pixels, got.col, got.row);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready)
                status_q.push_back(model_request(s_req_type, s_bus_req, s_bus_address,
                                                 s_bus_data, s_display_row));
        end
        outstanding <= status_q.size();
        mismatches  <= errs;
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the LED matrix bus peripheral
// Drives bus accesses and frame row reads under several base addresses with
// random idle gaps on both channels; a checker module beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import lmbp_pkg::*;

    logic               aclk;
    logic               aresetn;

    logic               cfg_valid;
    logic               cfg_ready;
    logic [31:0]        cfg_data;

    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic               s_bus_req;
    logic [31:0]        s_bus_address;
    logic signed [31:0] s_bus_data;
    logic [3:0]         s_display_row;

    logic               m_valid;
    logic               m_ready;
    logic               m_ack;
    logic [31:0]        m_row_pixels;
    logic [4:0]         m_cursor_col;
    logic [3:0]         m_cursor_row;

    int                 errors;
    int                 pending;

    // Base address the stimulus aims at; follows every cfg write.
    logic [31:0]        base_now;
    int                 sent_count;

    led_matrix_bus_peripheral u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_bus_req     (s_bus_req),
        .s_bus_address (s_bus_address),
        .s_bus_data    (s_bus_data),
        .s_display_row (s_display_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ack         (m_ack),
        .m_row_pixels  (m_row_pixels),
        .m_cursor_col  (m_cursor_col),
        .m_cursor_row  (m_cursor_row)
    );

    lmbp_frame_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_bus_req     (s_bus_req),
        .s_bus_address (s_bus_address),
        .s_bus_data    (s_bus_data),
        .s_display_row (s_display_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ack         (m_ack),
        .m_row_pixels  (m_row_pixels),
        .m_cursor_col  (m_cursor_col),
        .m_cursor_row  (m_cursor_row),
        .mismatches    (errors),
        .outstanding   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop. Worst case is ~1300 requests, each hit by the longest sender
    // gap and the longest result stall, about 2M time units; this is 15x that.
    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure: ready bursts broken by stalls. Some bursts
    // are long so there are stretches where results flow freely.
    initial begin : result_stall
        int burst;
        int gap;
        forever begin
            m_ready <= 1'b1;
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
            repeat (burst) @(posedge aclk);
            gap = idle_len();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Present one request and hold it until accepted, then maybe idle.
    // With no gap, valid simply stays high for the next request.
    task automatic send_item(input logic kind, input logic req, input logic [31:0] addr,
                             input logic [31:0] data, input logic [3:0] rsel);
        int gap;
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_bus_req     <= req;
        s_bus_address <= addr;
        s_bus_data    <= data;
        s_display_row <= rsel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // A proper bus cycle: request with req high (sets ack and acts if ack was low),
    // then a second request on the same address that drops ack again.
    task automatic bus_access(input reg_offset_t off, input logic [31:0] data);
        logic [31:0] addr;
        addr = base_now + 32'(off);
        send_item(REQ_BUS, 1'b1, addr, data, 4'($urandom));
        send_item(REQ_BUS, $urandom_range(0, 2) == 0, addr, $urandom, 4'($urandom));
    endtask

    // Stop sending, wait until every predicted result has been taken, then let
    // the clock run on to cover the two-stage pipeline.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_base(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        base_now = value;
    endtask

    // Data per register: mostly sensible values, with out-of-range cursor
    // values, zero/negative triggers and full 32-bit noise mixed in.
    function automatic logic [31:0] pick_data(reg_offset_t off);
        int r;
        r = $urandom_range(0, 99);
        case (off)
            OFF_CURSOR_X: begin
                if (r < 80) return $urandom_range(0, MATRIX_WIDTH - 1);
                else if (r < 88) return MATRIX_WIDTH;
                else if (r < 94) return 32'hFFFF_FFFF;
                else return $urandom;
            end
            OFF_CURSOR_Y: begin
                if (r < 80) return $urandom_range(0, MATRIX_HEIGHT - 1);
                else if (r < 88) return MATRIX_HEIGHT;
                else if (r < 94) return 32'hFFFF_FFFF;
                else return $urandom;
            end
            OFF_PIXEL: begin
                if (r < 45) return $urandom_range(1, 3);
                else if (r < 75) return 32'd0;
                else return $urandom;
            end
            default: begin
                if (r < 70) return 32'd1;
                else if (r < 80) return $urandom >> 1;
                else if (r < 90) return 32'd0;
                else return $urandom | 32'h8000_0000;
            end
        endcase
    endfunction

    // Address for a stray request: in the window, just past it, just below
    // it, or anywhere at all.
    function automatic logic [31:0] stray_addr();
        case ($urandom_range(0, 3))
            0:       return base_now + $urandom_range(0, 4);
            1:       return base_now + 5 + $urandom_range(0, 3);
            2:       return base_now - 1;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] bases [6];
        int          target;
        int          r;
        reg_offset_t pick_off;

        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_req_type    <= REQ_BUS;
        s_bus_req     <= 1'b0;
        s_bus_address <= '0;
        s_bus_data    <= '0;
        s_display_row <= '0;
        base_now       = BASE_ADDR_RESET;
        sent_count     = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: corners, clipping, ignored cursor writes, pixel on/off,
        // a shape with no trigger and an address just past the window.
        send_item(REQ_ROW, 1'b0, '0, '0, 4'd15);
        bus_access(OFF_CURSOR_X, 32'(MATRIX_WIDTH - 1));
        bus_access(OFF_CURSOR_Y, 32'(MATRIX_HEIGHT - 1));
        bus_access(OFF_SQUARE, 32'd1);
        bus_access(OFF_DIAMOND, 32'h7FFF_FFFF);
        bus_access(OFF_CURSOR_X, 32'hFFFF_FFFF);
        bus_access(OFF_CURSOR_Y, 32'(MATRIX_HEIGHT));
        bus_access(OFF_PIXEL, 32'h8000_0000);
        bus_access(OFF_PIXEL, 32'd1);
        for (int i = 15; i >= 13; i--)
            send_item(REQ_ROW, 1'b1, $urandom, $urandom, 4'(i));
        send_item(REQ_BUS, 1'b1, base_now + 5, 32'd1, 4'd0);
        bus_access(OFF_DIAMOND, 32'd0);

        // Base addresses per phase; the near-top values make the register
        // window wrap past address zero.
        bases[0] = 32'h0000_0000;
        bases[1] = 32'hFFFF_FFFF;
        bases[2] = 32'hFFFF_FFFD;
        bases[3] = $urandom;
        bases[4] = 32'h8000_0000;
        bases[5] = BASE_ADDR_RESET;

        for (int p = 0; p < 6; p++) begin
            drain();
            write_base(bases[p]);
            target = sent_count + 200;
            while (sent_count < target) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    send_item(REQ_ROW, 1'($urandom), $urandom, $urandom, 4'($urandom));
                end else if (r < 80) begin
                    pick_off = reg_offset_t'($urandom_range(0, 4));
                    bus_access(pick_off, pick_data(pick_off));
                end else begin
                    send_item(REQ_BUS, 1'($urandom), stray_addr(), $urandom,
                              4'($urandom));
                end
                // Occasionally let the pipeline empty completely mid-phase.
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
        end

        drain();
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
